### rtl/bgc_pkg.sv
`timescale 1ns / 1ps

package bgc_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 8;
  localparam int IntegW    = 10;

  typedef enum logic [3:0] {
    ST_IDLE         = 4'd0,
    ST_FIRST_START  = 4'd1,
    ST_FIRST_DIP    = 4'd2,
    ST_SECOND_START = 4'd3,
    ST_SECOND_DIP   = 4'd4,
    ST_PRESSED      = 4'd5,
    ST_DPRESSED     = 4'd6,
    ST_LONG         = 4'd7,
    ST_DLONG        = 4'd8
  } state_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_PRESS  = 3'd2,
    EV_LONG   = 3'd3,
    EV_DCLICK = 3'd4,
    EV_DPRESS = 3'd5,
    EV_DLONG  = 3'd6
  } event_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_START      = 3'd0,
    REG_CONFIRM    = 3'd1,
    REG_DIP        = 3'd2,
    REG_SINGLE_GAP = 3'd3,
    REG_DOUBLE_GAP = 3'd4,
    REG_LONG       = 3'd5,
    REG_RELEASE    = 3'd6
  } cfg_index_t;

  localparam logic [CfgDataW-1:0] START_RESET      = 8'd4;
  localparam logic [CfgDataW-1:0] CONFIRM_RESET    = 8'd8;
  localparam logic [CfgDataW-1:0] DIP_RESET        = 8'd3;
  localparam logic [CfgDataW-1:0] SINGLE_GAP_RESET = 8'd25;
  localparam logic [CfgDataW-1:0] DOUBLE_GAP_RESET = 8'd8;
  localparam logic [CfgDataW-1:0] LONG_RESET       = 8'd80;
  localparam logic [CfgDataW-1:0] RELEASE_RESET    = 8'd10;

  typedef struct packed {
    logic [CfgDataW-1:0] start_count;
    logic [CfgDataW-1:0] confirm_count;
    logic [CfgDataW-1:0] dip_count;
    logic [CfgDataW-1:0] single_gap_count;
    logic [CfgDataW-1:0] double_gap_count;
    logic [CfgDataW-1:0] long_count;
    logic [CfgDataW-1:0] release_count;
  } cfg_t;

  typedef struct packed {
    logic [3:0] gesture_state;
    logic [2:0] latched_event;
    logic       idle;
    logic       single_held;
    logic       single_long_held;
    logic       double_held;
    logic       double_long_held;
  } result_t;

endpackage

### rtl/bgc_cfg_regs.sv
`timescale 1ns / 1ps

module bgc_cfg_regs
  import bgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_en,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_count      <= START_RESET;
      cfg.confirm_count    <= CONFIRM_RESET;
      cfg.dip_count        <= DIP_RESET;
      cfg.single_gap_count <= SINGLE_GAP_RESET;
      cfg.double_gap_count <= DOUBLE_GAP_RESET;
      cfg.long_count       <= LONG_RESET;
      cfg.release_count    <= RELEASE_RESET;
    end else if (cfg_en) begin
      unique case (cfg_index_t'(cfg_index))
        REG_START:      cfg.start_count      <= cfg_data;
        REG_CONFIRM:    cfg.confirm_count    <= cfg_data;
        REG_DIP:        cfg.dip_count        <= cfg_data;
        REG_SINGLE_GAP: cfg.single_gap_count <= cfg_data;
        REG_DOUBLE_GAP: cfg.double_gap_count <= cfg_data;
        REG_LONG:       cfg.long_count       <= cfg_data;
        REG_RELEASE:    cfg.release_count    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/bgc_core.sv
`timescale 1ns / 1ps

module bgc_core
  import bgc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    accept,
  input  logic    action,
  input  logic    level,
  output result_t result
);

  state_t                    state;
  state_t                    state_next;
  event_t                    event_reg;
  event_t                    event_reg_next;
  logic signed [IntegW-1:0]  integrator;
  logic signed [IntegW-1:0]  integrator_next;
  logic signed [IntegW-1:0]  t;
  logic signed [IntegW-1:0]  pos_start;
  logic signed [IntegW-1:0]  pos_confirm;
  logic signed [IntegW-1:0]  pos_long;
  logic signed [IntegW-1:0]  neg_dip;
  logic signed [IntegW-1:0]  neg_single_gap;
  logic signed [IntegW-1:0]  neg_double_gap;
  logic signed [IntegW-1:0]  neg_release;
  logic signed [IntegW-1:0]  int_max;
  logic signed [IntegW-1:0]  int_min;

  assign int_max = {1'b0, {(IntegW-1){1'b1}}};
  assign int_min = {1'b1, {(IntegW-1){1'b0}}};

  assign pos_start      = $signed({2'b00, cfg.start_count});
  assign pos_confirm    = $signed({2'b00, cfg.confirm_count});
  assign pos_long       = $signed({2'b00, cfg.long_count});
  assign neg_dip        = -$signed({2'b00, cfg.dip_count});
  assign neg_single_gap = -$signed({2'b00, cfg.single_gap_count});
  assign neg_double_gap = -$signed({2'b00, cfg.double_gap_count});
  assign neg_release    = -$signed({2'b00, cfg.release_count});

  always_comb begin
    if (level) begin
      t = (integrator == int_max) ? integrator : integrator + 10'sd1;
    end else begin
      t = (integrator == int_min) ? integrator : integrator - 10'sd1;
    end
  end

  always_comb begin
    state_next      = state;
    event_reg_next  = event_reg;
    integrator_next = integrator;
    if (action) begin
      event_reg_next = EV_NONE;
    end else begin
      integrator_next = t;
      unique case (state)
        ST_FIRST_START: begin
          if (t == pos_confirm) begin
            state_next      = ST_PRESSED;
            integrator_next = '0;
            event_reg_next  = EV_PRESS;
          end else if (t == neg_dip) begin
            state_next      = ST_FIRST_DIP;
            integrator_next = '0;
          end
        end
        ST_FIRST_DIP: begin
          if (t == pos_confirm) begin
            state_next      = ST_SECOND_START;
            integrator_next = '0;
          end else if (t == neg_single_gap) begin
            state_next      = ST_IDLE;
            integrator_next = '0;
            event_reg_next  = EV_CLICK;
          end
        end
        ST_SECOND_START: begin
          if (t == pos_confirm) begin
            state_next      = ST_DPRESSED;
            integrator_next = '0;
            event_reg_next  = EV_DPRESS;
          end else if (t == neg_dip) begin
            state_next      = ST_SECOND_DIP;
            integrator_next = '0;
          end
        end
        ST_SECOND_DIP: begin
          if (t == pos_confirm) begin
            state_next      = ST_DPRESSED;
            integrator_next = '0;
          end else if (t == neg_double_gap) begin
            state_next      = ST_IDLE;
            integrator_next = '0;
            event_reg_next  = EV_DCLICK;
          end
        end
        ST_PRESSED: begin
          if (t > pos_long) begin
            state_next      = ST_LONG;
            integrator_next = '0;
            event_reg_next  = EV_LONG;
          end else if (t == neg_release) begin
            state_next      = ST_IDLE;
            integrator_next = '0;
          end
        end
        ST_DPRESSED: begin
          if (t > pos_long) begin
            state_next      = ST_DLONG;
            integrator_next = '0;
            event_reg_next  = EV_DLONG;
          end else if (t == neg_release) begin
            state_next      = ST_IDLE;
            integrator_next = '0;
          end
        end
        ST_LONG, ST_DLONG: begin
          if (t > 10'sd0) begin
            integrator_next = '0;
          end else if (t == neg_release) begin
            state_next      = ST_IDLE;
            integrator_next = '0;
          end
        end
        default: begin
          if (t < 10'sd0) begin
            integrator_next = '0;
          end else if (t == pos_start) begin
            state_next      = ST_FIRST_START;
            integrator_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      event_reg  <= EV_NONE;
      integrator <= '0;
    end else if (accept) begin
      state      <= state_next;
      event_reg  <= event_reg_next;
      integrator <= integrator_next;
    end
  end

  always_comb begin
    result.gesture_state    = state_next;
    result.latched_event    = event_reg_next;
    result.idle             = (state_next == ST_IDLE) && (event_reg_next == EV_NONE);
    result.single_held      = (state_next == ST_PRESSED) || (state_next == ST_LONG);
    result.single_long_held = (state_next == ST_LONG);
    result.double_held      = (state_next == ST_DPRESSED) || (state_next == ST_DLONG);
    result.double_long_held = (state_next == ST_DLONG);
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !integrator[IntegW-1])
    else $error("integrator negative while idle");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_LONG || state == ST_DLONG) |-> (integrator[IntegW-1] || integrator == '0))
    else $error("integrator positive in a long-press state");

  assert property (@(posedge clk) disable iff (rst)
    (accept && action) |=> (event_reg == EV_NONE && $stable(state) && $stable(integrator)))
    else $error("end of frame did more than clear the event");

endmodule

### rtl/bgc_out_buf.sv
`timescale 1ns / 1ps

module bgc_out_buf
  import bgc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      main_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else if (pop || !main_valid) begin
      main_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      main_data <= skid_data;
    end else if (pop || !main_valid) begin
      main_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held without a head entry");

  assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(main_valid && !out_ready && push))
    else $error("skid entry filled while the head entry was free");

endmodule

### rtl/button_gesture_classifier.sv
`timescale 1ns / 1ps

// Button gesture classifier.
// Input channel (in_valid / in_ready, fields action and level): each
// transaction is one button sample (action low) or an end-of-frame mark
// (action high) that clears the latched gesture event.
// Output channel (out_valid / out_ready): exactly one result transaction per
// input transaction, in order, carrying the state, the latched event, the
// idle flag and the held-press flags as they stand after that input.
// The result is registered in the output buffer before it shows on out_valid;
// one input is accepted every cycle while in_ready is high, since each input
// updates the state, event and integrator registers as it is accepted.
// Results pass through a two-entry output buffer, so a new input is still
// taken while one result waits; in_ready drops once both entries are full,
// which happens once a result waits with out_ready low and a new input is
// accepted.
// Reset (rst, synchronous) returns to idle with no event, a zero integrator,
// an empty output buffer and the default thresholds. The user must write the
// thresholds through cfg_en / cfg_index / cfg_data only while no transaction
// is in flight; the block itself does not enforce this.

module button_gesture_classifier
  import bgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic                 level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           gesture_state,
  output logic [2:0]           latched_event,
  output logic                 idle,
  output logic                 single_held,
  output logic                 single_long_held,
  output logic                 double_held,
  output logic                 double_long_held,
  input  logic                 cfg_en,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t core_result;
  result_t out_data;
  logic    space;
  logic    accept;

  assign in_ready = space;
  assign accept   = in_valid && space;

  bgc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .action (action),
    .level  (level),
    .result (core_result)
  );

  bgc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign gesture_state    = out_data.gesture_state;
  assign latched_event    = out_data.latched_event;
  assign idle             = out_data.idle;
  assign single_held      = out_data.single_held;
  assign single_long_held = out_data.single_long_held;
  assign double_held      = out_data.double_held;
  assign double_long_held = out_data.double_long_held;

endmodule

### tb/sv/gesture_checker.sv
`timescale 1ns / 1ps

module gesture_checker
  import bgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 action,
  input  logic                 level,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [3:0]           gesture_state,
  input  logic [2:0]           latched_event,
  input  logic                 idle,
  input  logic                 single_held,
  input  logic                 single_long_held,
  input  logic                 double_held,
  input  logic                 double_long_held,
  input  logic                 cfg_en,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int IntegMax = 2 ** (IntegW - 1) - 1;
  localparam int IntegMin = -(2 ** (IntegW - 1));

  cfg_t                     thr;
  state_t                   st;
  event_t                   ev;
  logic signed [IntegW-1:0] integ;
  result_t                  expected_q[$];

  task automatic move_to(input state_t nxt);
    st = nxt;
    integ = '0;
  endtask

  task automatic take_sample(input logic lvl);
    int t;
    t = int'(integ) + (lvl ? 1 : -1);
    if (t > IntegMax) t = IntegMax;
    if (t < IntegMin) t = IntegMin;
    integ = t[IntegW-1:0];
    case (st)
      ST_FIRST_START: begin
        if (t == int'(thr.confirm_count)) begin
          move_to(ST_PRESSED);
          ev = EV_PRESS;
        end else if (t == -int'(thr.dip_count)) begin
          move_to(ST_FIRST_DIP);
        end
      end
      ST_FIRST_DIP: begin
        if (t == int'(thr.confirm_count)) begin
          move_to(ST_SECOND_START);
        end else if (t == -int'(thr.single_gap_count)) begin
          move_to(ST_IDLE);
          ev = EV_CLICK;
        end
      end
      ST_SECOND_START: begin
        if (t == int'(thr.confirm_count)) begin
          move_to(ST_DPRESSED);
          ev = EV_DPRESS;
        end else if (t == -int'(thr.dip_count)) begin
          move_to(ST_SECOND_DIP);
        end
      end
      ST_SECOND_DIP: begin
        if (t == int'(thr.confirm_count)) begin
          move_to(ST_DPRESSED);
        end else if (t == -int'(thr.double_gap_count)) begin
          move_to(ST_IDLE);
          ev = EV_DCLICK;
        end
      end
      ST_PRESSED: begin
        if (t > int'(thr.long_count)) begin
          move_to(ST_LONG);
          ev = EV_LONG;
        end else if (t == -int'(thr.release_count)) begin
          move_to(ST_IDLE);
        end
      end
      ST_DPRESSED: begin
        if (t > int'(thr.long_count)) begin
          move_to(ST_DLONG);
          ev = EV_DLONG;
        end else if (t == -int'(thr.release_count)) begin
          move_to(ST_IDLE);
        end
      end
      ST_LONG, ST_DLONG: begin
        if (t > 0) begin
          integ = '0;
        end else if (t == -int'(thr.release_count)) begin
          move_to(ST_IDLE);
        end
      end
      default: begin
        if (t < 0) begin
          integ = '0;
        end else if (t == int'(thr.start_count)) begin
          move_to(ST_FIRST_START);
        end
      end
    endcase
  endtask

  function automatic result_t gesture_view();
    result_t r;
    r.gesture_state    = st;
    r.latched_event    = ev;
    r.idle             = (st == ST_IDLE) && (ev == EV_NONE);
    r.single_held      = (st == ST_PRESSED) || (st == ST_LONG);
    r.single_long_held = (st == ST_LONG);
    r.double_held      = (st == ST_DPRESSED) || (st == ST_DLONG);
    r.double_long_held = (st == ST_DLONG);
    return r;
  endfunction

  function automatic int field_diff(input string name, input int want_v, input int got_v);
    if (want_v == got_v) return 0;
    $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    int      errs;
    if (rst) begin
      thr.start_count      = START_RESET;
      thr.confirm_count    = CONFIRM_RESET;
      thr.dip_count        = DIP_RESET;
      thr.single_gap_count = SINGLE_GAP_RESET;
      thr.double_gap_count = DOUBLE_GAP_RESET;
      thr.long_count       = LONG_RESET;
      thr.release_count    = RELEASE_RESET;
      st = ST_IDLE;
      ev = EV_NONE;
      integ = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, state %0d event %0d", $time, gesture_state,
                   latched_event);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          errs = 0;
          errs += field_diff("gesture_state", want.gesture_state, gesture_state);
          errs += field_diff("latched_event", want.latched_event, latched_event);
          errs += field_diff("idle", want.idle, idle);
          errs += field_diff("single_held", want.single_held, single_held);
          errs += field_diff("single_long_held", want.single_long_held, single_long_held);
          errs += field_diff("double_held", want.double_held, double_held);
          errs += field_diff("double_long_held", want.double_long_held, double_long_held);
          fail_count += errs;
        end
      end
      if (in_valid && in_ready) begin
        if (action) ev = EV_NONE;
        else take_sample(level);
        expected_q.push_back(gesture_view());
      end
      if (cfg_en) begin
        case (cfg_index_t'(cfg_index))
          REG_START:      thr.start_count      = cfg_data;
          REG_CONFIRM:    thr.confirm_count    = cfg_data;
          REG_DIP:        thr.dip_count        = cfg_data;
          REG_SINGLE_GAP: thr.single_gap_count = cfg_data;
          REG_DOUBLE_GAP: thr.double_gap_count = cfg_data;
          REG_LONG:       thr.long_count       = cfg_data;
          REG_RELEASE:    thr.release_count    = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bgc_pkg::*;

  localparam logic ACT_SAMPLE    = 1'b0;
  localparam logic ACT_FRAME_END = 1'b1;
  localparam int   HoldCycles    = 80;

  typedef enum int {S_LOW, S_HIGH, S_EOF} stim_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 action = 1'b0;
  logic                 level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [3:0]           gesture_state;
  logic [2:0]           latched_event;
  logic                 idle;
  logic                 single_held;
  logic                 single_long_held;
  logic                 double_held;
  logic                 double_long_held;
  logic                 cfg_en = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  int                   fail_count;
  int                   pending;

  logic [CfgDataW-1:0] cur_thr [7];
  int                  items_sent = 0;
  int                  stop_at = 0;
  int                  gap_pct = 20;
  int                  stall_pct = 20;
  logic                quiet = 1'b0;
  logic                hold_req = 1'b0;

  stim_t directed_seq [29] = '{
    S_LOW, S_HIGH, S_LOW, S_LOW,
    S_HIGH, S_HIGH, S_HIGH, S_HIGH, S_LOW,
    S_HIGH, S_LOW, S_HIGH, S_HIGH, S_HIGH, S_HIGH, S_HIGH, S_LOW,
    S_HIGH, S_LOW, S_HIGH, S_LOW, S_LOW, S_EOF,
    S_HIGH, S_LOW, S_HIGH, S_LOW, S_HIGH, S_LOW
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  button_gesture_classifier dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .level(level),
    .out_valid(out_valid), .out_ready(out_ready),
    .gesture_state(gesture_state), .latched_event(latched_event), .idle(idle),
    .single_held(single_held), .single_long_held(single_long_held),
    .double_held(double_held), .double_long_held(double_long_held),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gesture_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .level(level),
    .out_valid(out_valid), .out_ready(out_ready),
    .gesture_state(gesture_state), .latched_event(latched_event), .idle(idle),
    .single_held(single_held), .single_long_held(single_long_held),
    .double_held(double_held), .double_long_held(double_long_held),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  task automatic send_item(input logic act, input logic lvl);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    level    <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_thresholds();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_en    <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data  <= cur_thr[i];
      @(negedge clk);
    end
    cfg_en <= 1'b0;
  endtask

  function automatic int run_len();
    int a;
    a = int'(cur_thr[$urandom_range(0, 6)]);
    if ($urandom_range(0, 1)) a += int'(cur_thr[$urandom_range(0, 6)]);
    if ($urandom_range(0, 6) == 0)
      a = int'(cur_thr[REG_START]) + int'(cur_thr[REG_CONFIRM]) + int'(cur_thr[REG_LONG]) + 2;
    a += int'($urandom_range(0, 2)) - 1;
    return (a < 1) ? 1 : a;
  endfunction

  // A run of one level, sprinkled with stray samples and frame ends.
  task automatic play_run(input logic lvl, input int len);
    int r;
    for (int k = 0; k < len && items_sent < stop_at; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_item(ACT_FRAME_END, 1'($urandom_range(0, 1)));
      else if (r < 6) send_item(ACT_SAMPLE, ~lvl);
      else send_item(ACT_SAMPLE, lvl);
    end
  endtask

  task automatic run_traffic(input int budget);
    logic lvl;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          if (items_sent < stop_at)
            send_item($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
        end
      end else begin
        lvl = 1'b1;
        repeat ($urandom_range(2, 6)) begin
          play_run(lvl, run_len());
          lvl = ~lvl;
        end
        if ($urandom_range(0, 1) && items_sent < stop_at)
          send_item(ACT_FRAME_END, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    cur_thr[REG_START]      = START_RESET;
    cur_thr[REG_CONFIRM]    = CONFIRM_RESET;
    cur_thr[REG_DIP]        = DIP_RESET;
    cur_thr[REG_SINGLE_GAP] = SINGLE_GAP_RESET;
    cur_thr[REG_DOUBLE_GAP] = DOUBLE_GAP_RESET;
    cur_thr[REG_LONG]       = LONG_RESET;
    cur_thr[REG_RELEASE]    = RELEASE_RESET;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_traffic(100);

    // With every threshold at one, each transition but the long press takes a single sample; the long press takes two.
    gap_pct = 0;
    stall_pct = 0;
    foreach (cur_thr[i]) cur_thr[i] = 8'd1;
    write_thresholds();
    foreach (directed_seq[i]) begin
      if (directed_seq[i] == S_EOF) send_item(ACT_FRAME_END, 1'b1);
      else send_item(ACT_SAMPLE, directed_seq[i] == S_HIGH);
    end
    run_traffic(80);

    gap_pct = 10;
    stall_pct = 25;
    foreach (cur_thr[i]) cur_thr[i] = 8'd255;
    cur_thr[REG_START] = 8'd1;
    cur_thr[REG_DIP]   = 8'd1;
    write_thresholds();
    run_traffic(220);

    gap_pct = 5;
    stall_pct = 10;
    foreach (cur_thr[i]) cur_thr[i] = 8'd255;
    write_thresholds();
    hold_req = 1'b1;
    run_traffic(180);

    repeat (2) begin
      gap_pct = $urandom_range(0, 40);
      stall_pct = $urandom_range(0, 40);
      foreach (cur_thr[i]) cur_thr[i] = CfgDataW'($urandom_range(1, 12));
      write_thresholds();
      run_traffic(80);
    end

    quiet = 1'b1;
    foreach (cur_thr[i]) cur_thr[i] = CfgDataW'($urandom_range(1, 255));
    write_thresholds();
    run_traffic(80);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bgc_pkg.sv
rtl/bgc_cfg_regs.sv
rtl/bgc_core.sv
rtl/bgc_out_buf.sv
rtl/button_gesture_classifier.sv
tb/sv/gesture_checker.sv
tb/sv/testbench.sv
